@@ src/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and constants shared by the MIDI track event parser modules.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned TRACKS_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    CMD_BYTE   = 1'b0,
    CMD_REWIND = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_CHANNEL = 3'd0,
    KIND_META    = 3'd1,
    KIND_SYSEX   = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1  = 3'd2,
    PH_DATA2  = 3'd3,
    PH_MTYPE  = 3'd4,
    PH_LEN    = 3'd5,
    PH_PAY    = 3'd6
  } phase_t;

  localparam logic [7:0] STATUS_NONE = 8'h0F;
  localparam logic [7:0] STATUS_META = 8'hFF;
  localparam logic [7:0] STATUS_SYS  = 8'hF0;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] DATA_MASK   = 8'h7F;
  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_PRESS    = 4'hD;
  localparam logic [3:0] HI_BEND     = 4'hE;

  typedef struct packed {
    logic       cmd;
    logic [3:0] track;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  track_out;
    logic [31:0] delta_ticks;
    logic [3:0]  status_nibble;
    logic [3:0]  channel;
    logic [7:0]  number;
    logic [14:0] value;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } out_item_t;

  // per-track parse context
  typedef struct packed {
    logic [7:0]  running_status;
    logic        ended;
    logic        halted;
    phase_t      phase;
    logic [31:0] ticks;
    logic [7:0]  first_data;
    logic [7:0]  event_status;
    logic [31:0] remaining;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    running_status: STATUS_NONE, ended: 1'b0, halted: 1'b0, phase: PH_DELTA,
    ticks: 32'd0, first_data: 8'd0, event_status: 8'd0, remaining: 32'd0
  };

endpackage

@@ src/mtep_front.sv @@
// ----------------------------------------------------------------------------
// mtep_front
// Accepts track bytes and drops those for tracks out of range.
// ----------------------------------------------------------------------------
module mtep_front #(
  parameter int unsigned TRACKS = mtep_pkg::TRACKS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mtep_pkg::in_item_t in_item,
  output logic               q_valid,
  input  logic               q_ready,
  output mtep_pkg::in_item_t q_item
);
  import mtep_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  in_item_t    mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          wr_en;
  logic          rd_en;
  logic          in_range;

  assign in_range = (9'(in_item.track) < 9'(TRACKS));
  assign full     = (count == (AW + 1)'(QUEUE_DEPTH));
  assign wr_en    = push && !full && in_range;
  assign q_valid  = (count != '0);
  assign rd_en    = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW + 1)'(wr_en) - (AW + 1)'(rd_en);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (AW + 1)'(QUEUE_DEPTH)) else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !rd_en) else $error("pop of empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> (count == $past(count) + 1'b1)) else $error("count");

endmodule

@@ src/mtep_back.sv @@
// ----------------------------------------------------------------------------
// mtep_back
// Per-track parse engine and result register.
// ----------------------------------------------------------------------------
module mtep_back #(
  parameter int unsigned TRACKS = mtep_pkg::TRACKS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  mtep_pkg::in_item_t  q_item,
  output logic                empty,
  input  logic                pop,
  output mtep_pkg::out_item_t out_item
);
  import mtep_pkg::*;

  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  ctx_t       ctx [TRACKS];
  logic       out_valid;
  out_item_t  res;
  logic       res_valid;
  ctx_t       cur;
  ctx_t       nxt;
  logic [3:0] hi;
  logic [7:0] b;
  logic       take;
  logic [TW-1:0] idx;

  assign q_ready = !out_valid || pop;
  assign take    = q_valid && q_ready;
  assign empty   = !out_valid;
  assign idx     = TW'(q_item.track);
  assign cur     = ctx[idx];
  assign b       = q_item.data_byte;

  always_comb begin
    nxt       = cur;
    res       = '0;
    res_valid = 1'b0;
    hi        = cur.event_status[7:4];
    res.track_out = q_item.track;
    res.channel   = 4'hF;
    if (q_item.cmd == CMD_REWIND) begin
      nxt = CTX_RESET;
    end else if (cur.halted || (cur.ended && cur.phase != PH_PAY)) begin
      nxt = cur;
    end else begin
      unique case (cur.phase)
        PH_DELTA: begin
          nxt.ticks = {cur.ticks[24:0], b[6:0]};
          if (!b[7]) nxt.phase = PH_STATUS;
        end
        PH_STATUS, PH_DATA1: begin
          if (cur.phase == PH_STATUS && b[7]) begin
            nxt.event_status = b;
            if (b == STATUS_META) begin
              nxt.running_status = STATUS_NONE;
              nxt.phase = PH_MTYPE;
            end else if (b >= STATUS_SYS) begin
              nxt.running_status = STATUS_NONE;
              nxt.first_data = {4'h0, b[3:0]};
              nxt.remaining = '0;
              nxt.phase = PH_LEN;
            end else begin
              nxt.running_status = b;
              nxt.phase = PH_DATA1;
            end
          end else if (cur.phase == PH_STATUS && !cur.running_status[7]) begin
            res_valid = 1'b1;
            res.kind = KIND_ERROR;
            res.delta_ticks = cur.ticks;
            res.number = b;
            nxt.halted = 1'b1;
          end else begin
            if (cur.phase == PH_STATUS) begin
              nxt.event_status = cur.running_status;
              hi = cur.running_status[7:4];
            end
            if (hi == HI_PROG || hi == HI_PRESS) begin
              res_valid = 1'b1;
              res.kind = KIND_CHANNEL;
              res.delta_ticks = cur.ticks;
              res.status_nibble = hi;
              res.channel = nxt.event_status[3:0];
              res.value = {7'd0, b};
              nxt.ticks = '0;
              nxt.phase = PH_DELTA;
            end else begin
              nxt.first_data = b;
              nxt.phase = PH_DATA2;
            end
          end
        end
        PH_DATA2: begin
          res_valid = 1'b1;
          res.kind = KIND_CHANNEL;
          res.delta_ticks = cur.ticks;
          res.status_nibble = hi;
          res.channel = cur.event_status[3:0];
          if (hi == HI_BEND) begin
            res.value = {1'b0, b[6:0], cur.first_data[6:0]};
          end else begin
            res.number = cur.first_data;
            res.value = {7'd0, b};
          end
          nxt.ticks = '0;
          nxt.phase = PH_DELTA;
        end
        PH_MTYPE: begin
          nxt.first_data = b;
          nxt.remaining = '0;
          nxt.phase = PH_LEN;
        end
        PH_LEN: begin
          nxt.remaining = {cur.remaining[24:0], b[6:0]};
          if (!b[7]) begin
            res_valid = 1'b1;
            res.kind = (cur.event_status == STATUS_META) ? KIND_META : KIND_SYSEX;
            res.delta_ticks = cur.ticks;
            res.status_nibble = 4'hF;
            res.number = cur.first_data;
            res.payload_length = nxt.remaining;
            if (cur.event_status == STATUS_META && cur.first_data == META_EOT)
              nxt.ended = 1'b1;
            nxt.ticks = '0;
            nxt.phase = (nxt.remaining != '0) ? PH_PAY : PH_DELTA;
          end
        end
        PH_PAY: begin
          res_valid = 1'b1;
          res.kind = KIND_PAYLOAD;
          res.status_nibble = 4'hF;
          res.number = cur.first_data;
          res.payload_byte = b;
          res.payload_last = (cur.remaining == 32'd1);
          nxt.remaining = cur.remaining - 32'd1;
          if (cur.remaining == 32'd1) nxt.phase = PH_DELTA;
        end
        default: begin
          nxt.phase = PH_DELTA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACKS; i++) ctx[i] <= CTX_RESET;
    end else if (take) begin
      ctx[idx] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) out_item <= res;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid) else $error("result lost");
  a_no_take_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |-> !take) else $error("overwrite of result");
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> $stable(out_item)) else $error("result changed");

endmodule

@@ src/midi_track_event_parser.sv @@
// path: an accepted track byte is stored in the queue, then parsed into the result register
// throughput: one byte per cycle while the result register is free or being popped
// a short queue decouples input from the parse engine; results wait in one register
// reset: synchronous rst clears queue, result register and every track context
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Standard MIDI file track event parser, interleaved tracks, one byte a cycle unless results back up.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
  parameter int unsigned TRACKS = mtep_pkg::TRACKS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mtep_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output mtep_pkg::out_item_t out_item
);
  import mtep_pkg::*;

  logic     q_valid;
  logic     q_ready;
  in_item_t q_item;

  mtep_front #(.TRACKS(TRACKS)) u_front (
    .clk, .rst, .push, .full, .in_item, .q_valid, .q_ready, .q_item
  );

  mtep_back #(.TRACKS(TRACKS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .empty, .pop, .out_item
  );

endmodule

@@ test/tb_midi_track_event_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_track_event_parser
// Drives interleaved track byte streams into the MIDI event parser, predicts
// every event, header, payload byte and error from a per-track parse model,
// and compares each popped result against it. A directed table of events comes
// first, then random well-formed events mixed with noise, rewinds and bad bytes.
// Both sides idle at random, and once the consumer stalls long enough to fill
// the block.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser;
  import mtep_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_TRACKS = 16;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic empty;
  logic pop;
  in_item_t in_item;
  out_item_t out_item;

  midi_track_event_parser DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  ctx_t trk [NUM_TRACKS];
  out_item_t pending_events[$];
  int errors = 0;
  int idle_cycles = 0;
  bit sending_done = 0;
  bit long_hold = 0;
  bit last_valid = 0;
  out_item_t last_pred;

  typedef struct {
    in_item_t item;
    bit has_exp;
    out_item_t exp;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic out_item_t make_event(kind_t k, logic [3:0] t, logic [31:0] d,
      logic [3:0] st, logic [3:0] ch, logic [7:0] num, logic [14:0] val,
      logic [31:0] len, logic [7:0] pb, logic last);
    out_item_t o;
    o.kind = k; o.track_out = t; o.delta_ticks = d; o.status_nibble = st;
    o.channel = ch; o.number = num; o.value = val; o.payload_length = len;
    o.payload_byte = pb; o.payload_last = last;
    return o;
  endfunction

  function automatic bit decode_first(logic [3:0] t, logic [7:0] b, output out_item_t o);
    logic [3:0] hi;
    hi = trk[t].event_status[7:4];
    if (hi == HI_PROG || hi == HI_PRESS) begin
      o = make_event(KIND_CHANNEL, t, trk[t].ticks, hi, trk[t].event_status[3:0],
                     8'd0, {7'd0, b}, 32'd0, 8'd0, 1'b0);
      trk[t].ticks = 0;
      trk[t].phase = PH_DELTA;
      return 1;
    end
    trk[t].first_data = b;
    trk[t].phase = PH_DATA2;
    return 0;
  endfunction

  function automatic bit parse_byte(in_item_t it, output out_item_t o);
    logic [3:0] t;
    logic [7:0] b;
    logic [3:0] hi;
    t = it.track;
    b = it.data_byte;
    o = '0;
    if (it.cmd == CMD_REWIND) begin
      trk[t] = CTX_RESET;
      return 0;
    end
    if (trk[t].halted) return 0;
    if (trk[t].ended && trk[t].phase != PH_PAY) return 0;
    case (trk[t].phase)
      PH_DELTA: begin
        trk[t].ticks = {trk[t].ticks[24:0], b[6:0]};
        if (!b[7]) trk[t].phase = PH_STATUS;
        return 0;
      end
      PH_STATUS: begin
        if (b[7]) begin
          trk[t].event_status = b;
          if (b == STATUS_META) begin
            trk[t].running_status = STATUS_NONE;
            trk[t].phase = PH_MTYPE;
          end else if (b >= STATUS_SYS) begin
            trk[t].running_status = STATUS_NONE;
            trk[t].first_data = {4'd0, b[3:0]};
            trk[t].remaining = 0;
            trk[t].phase = PH_LEN;
          end else begin
            trk[t].running_status = b;
            trk[t].phase = PH_DATA1;
          end
          return 0;
        end
        if (!trk[t].running_status[7]) begin
          o = make_event(KIND_ERROR, t, trk[t].ticks, 4'd0, 4'hF, b, 15'd0,
                         32'd0, 8'd0, 1'b0);
          trk[t].halted = 1;
          return 1;
        end
        trk[t].event_status = trk[t].running_status;
        return decode_first(t, b, o);
      end
      PH_DATA1: return decode_first(t, b, o);
      PH_DATA2: begin
        hi = trk[t].event_status[7:4];
        if (hi == HI_BEND)
          o = make_event(KIND_CHANNEL, t, trk[t].ticks, hi, trk[t].event_status[3:0],
                         8'd0, {1'b0, b[6:0], trk[t].first_data[6:0]}, 32'd0, 8'd0,
                         1'b0);
        else
          o = make_event(KIND_CHANNEL, t, trk[t].ticks, hi, trk[t].event_status[3:0],
                         trk[t].first_data, {7'd0, b}, 32'd0, 8'd0, 1'b0);
        trk[t].ticks = 0;
        trk[t].phase = PH_DELTA;
        return 1;
      end
      PH_MTYPE: begin
        trk[t].first_data = b;
        trk[t].remaining = 0;
        trk[t].phase = PH_LEN;
        return 0;
      end
      PH_LEN: begin
        trk[t].remaining = {trk[t].remaining[24:0], b[6:0]};
        if (b[7]) return 0;
        if (trk[t].event_status == STATUS_META) begin
          o = make_event(KIND_META, t, trk[t].ticks, 4'hF, 4'hF, trk[t].first_data,
                         15'd0, trk[t].remaining, 8'd0, 1'b0);
          if (trk[t].first_data == META_EOT) trk[t].ended = 1;
        end else begin
          o = make_event(KIND_SYSEX, t, trk[t].ticks, 4'hF, 4'hF, trk[t].first_data,
                         15'd0, trk[t].remaining, 8'd0, 1'b0);
        end
        trk[t].ticks = 0;
        trk[t].phase = (trk[t].remaining != 0) ? PH_PAY : PH_DELTA;
        return 1;
      end
      PH_PAY: begin
        o = make_event(KIND_PAYLOAD, t, 32'd0, 4'hF, 4'hF, trk[t].first_data, 15'd0,
                       32'd0, b, trk[t].remaining == 1);
        trk[t].remaining = trk[t].remaining - 1;
        if (trk[t].remaining == 0) trk[t].phase = PH_DELTA;
        return 1;
      end
      default: begin
        trk[t].phase = PH_DELTA;
        return 0;
      end
    endcase
  endfunction

  task automatic send_byte(logic c, logic [3:0] t, logic [7:0] b);
    int gap;
    in_item_t it;
    out_item_t o;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.cmd = c; it.track = t; it.data_byte = b;
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    last_valid = parse_byte(it, o);
    last_pred = o;
    if (last_valid) pending_events.push_back(o);
  endtask

  task automatic send_vlq(logic [3:0] t, logic [31:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--)
      send_byte(CMD_BYTE, t, {i != 0, 7'((v >> (7 * i)) & 32'h7F)});
  endtask

  task automatic send_random_event(logic [3:0] t);
    int sel;
    int len;
    logic [7:0] st;
    sel = $urandom_range(0, 19);
    send_vlq(t, $urandom, $urandom_range(1, 3) == 3 ? $urandom_range(1, 6) : 1);
    if (sel < 12) begin
      if (sel >= 4 || !trk[t].running_status[7])
        send_byte(CMD_BYTE, t, {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)});
      send_byte(CMD_BYTE, t, 8'($urandom));
      send_byte(CMD_BYTE, t, 8'($urandom));
    end else if (sel < 18) begin
      st = (sel < 15) ? STATUS_META : 8'($urandom_range(8'hF0, 8'hFE));
      len = $urandom_range(0, 4);
      send_byte(CMD_BYTE, t, st);
      if (st == STATUS_META)
        send_byte(CMD_BYTE, t, $urandom_range(0, 30) == 0 ? META_EOT : 8'($urandom));
      send_vlq(t, len, $urandom_range(0, 5) == 0 ? 2 : 1);
      repeat (len) send_byte(CMD_BYTE, t, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4))
        send_byte($urandom_range(0, 15) == 0 ? CMD_REWIND : CMD_BYTE, t, 8'($urandom));
    end
  endtask

  task automatic add_row(logic c, logic [3:0] t, logic [7:0] b, bit he, out_item_t e);
    dir_row_t r;
    r.item.cmd = c; r.item.track = t; r.item.data_byte = b;
    r.has_exp = he; r.exp = e;
    dir_rows.push_back(r);
  endtask

  initial begin
    out_item_t none;
    none = '0;
    // note on, full delta
    add_row(CMD_BYTE, 0, 8'h83, 0, none);
    add_row(CMD_BYTE, 0, 8'h00, 0, none);
    add_row(CMD_BYTE, 0, 8'h9F, 0, none);
    add_row(CMD_BYTE, 0, 8'hFF, 0, none);
    add_row(CMD_BYTE, 0, 8'h00, 1, make_event(KIND_CHANNEL, 0, 32'h180, 4'h9, 4'hF,
            8'hFF, 15'd0, 32'd0, 8'd0, 1'b0));
    // running status, then pitch bend
    add_row(CMD_BYTE, 0, 8'h00, 0, none);
    add_row(CMD_BYTE, 0, 8'h01, 0, none);
    add_row(CMD_BYTE, 0, 8'h02, 0, none);
    add_row(CMD_BYTE, 0, 8'h7F, 0, none);
    add_row(CMD_BYTE, 0, 8'hE3, 0, none);
    add_row(CMD_BYTE, 0, 8'hFF, 0, none);
    add_row(CMD_BYTE, 0, 8'hFF, 1, make_event(KIND_CHANNEL, 0, 32'h7F, 4'hE, 4'h3,
            8'd0, 15'h3FFF, 32'd0, 8'd0, 1'b0));
    // data byte with no running status
    add_row(CMD_BYTE, 15, 8'h05, 0, none);
    add_row(CMD_BYTE, 15, 8'h40, 1, make_event(KIND_ERROR, 15, 32'd5, 4'd0, 4'hF,
            8'h40, 15'd0, 32'd0, 8'd0, 1'b0));
    add_row(CMD_BYTE, 15, 8'h00, 0, none);
    add_row(CMD_REWIND, 15, 8'hAA, 0, none);
    // end of track with payload, then an ignored byte
    add_row(CMD_BYTE, 15, 8'h00, 0, none);
    add_row(CMD_BYTE, 15, 8'hFF, 0, none);
    add_row(CMD_BYTE, 15, META_EOT, 0, none);
    add_row(CMD_BYTE, 15, 8'h01, 1, make_event(KIND_META, 15, 32'd0, 4'hF, 4'hF,
            META_EOT, 15'd0, 32'd1, 8'd0, 1'b0));
    add_row(CMD_BYTE, 15, 8'h80, 1, make_event(KIND_PAYLOAD, 15, 32'd0, 4'hF, 4'hF,
            META_EOT, 15'd0, 32'd0, 8'h80, 1'b1));
    add_row(CMD_BYTE, 15, 8'hC0, 0, none);
    // sysex; a program change follows after the table
    add_row(CMD_BYTE, 1, 8'h00, 0, none);
    add_row(CMD_BYTE, 1, 8'hF7, 0, none);
    add_row(CMD_BYTE, 1, 8'h00, 1, make_event(KIND_SYSEX, 1, 32'd0, 4'hF, 4'hF,
            8'h07, 15'd0, 32'd0, 8'd0, 1'b0));
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    for (int t = 0; t < NUM_TRACKS; t++) trk[t] = CTX_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].item.cmd, dir_rows[i].item.track, dir_rows[i].item.data_byte);
      if (dir_rows[i].has_exp && (!last_valid || last_pred !== dir_rows[i].exp)) begin
        $error("directed row %0d: expected %h, actual %h", i, dir_rows[i].exp,
               last_pred);
        errors++;
      end
    end
    send_byte(CMD_BYTE, 1, 8'h00);
    send_byte(CMD_BYTE, 1, 8'hC5);
    send_byte(CMD_BYTE, 1, 8'hA7);
    for (int t = 0; t < NUM_TRACKS; t++) send_byte(CMD_REWIND, t, 8'h00);
    for (int n = 0; n < 130; n++) begin
      if (n == 40) long_hold = 1;
      send_random_event($urandom_range(0, 15));
    end
    push <= 1'b0;
    sending_done = 1;
  end

  initial begin
    int gap;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else begin
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_events.size() == 0) begin
        $error("unexpected transaction: %p", out_item);
        errors++;
      end else begin
        out_item_t e;
        e = pending_events.pop_front();
        if (out_item.kind !== e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, out_item.kind); errors++; end
        if (out_item.track_out !== e.track_out) begin
          $error("track_out: expected %0d, actual %0d", e.track_out, out_item.track_out);
          errors++; end
        if (out_item.delta_ticks !== e.delta_ticks) begin
          $error("delta_ticks: expected %0d, actual %0d", e.delta_ticks,
                 out_item.delta_ticks); errors++; end
        if (out_item.status_nibble !== e.status_nibble) begin
          $error("status_nibble: expected %0d, actual %0d", e.status_nibble,
                 out_item.status_nibble); errors++; end
        if (out_item.channel !== e.channel) begin
          $error("channel: expected %0d, actual %0d", e.channel, out_item.channel);
          errors++; end
        if (out_item.number !== e.number) begin
          $error("number: expected %0d, actual %0d", e.number, out_item.number);
          errors++; end
        if (out_item.value !== e.value) begin
          $error("value: expected %0d, actual %0d", e.value, out_item.value); errors++; end
        if (out_item.payload_length !== e.payload_length) begin
          $error("payload_length: expected %0d, actual %0d", e.payload_length,
                 out_item.payload_length); errors++; end
        if (out_item.payload_byte !== e.payload_byte) begin
          $error("payload_byte: expected %0d, actual %0d", e.payload_byte,
                 out_item.payload_byte); errors++; end
        if (out_item.payload_last !== e.payload_last) begin
          $error("payload_last: expected %0d, actual %0d", e.payload_last,
                 out_item.payload_last); errors++; end
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (sending_done && pending_events.size() == 0) begin
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_events.size() == 0 && empty)
          $display("end of test: clean");
        else
          $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
src/mtep_pkg.sv
src/mtep_front.sv
src/mtep_back.sv
src/midi_track_event_parser.sv
test/tb_midi_track_event_parser.sv
